// ----- src/tlsf_pkg.sv -----
// Package: constants, request and response types, and size-class helpers of the heap manager.
package tlsf_pkg;

    localparam int HEAP_BYTES      = 65536;
    localparam int GRAIN_BYTES     = 4;
    localparam int SIZE_CLASSES    = 17;
    localparam int SLOTS_PER_CLASS = 4;

    // Heap size and grain are powers of two, so word index and rounding are masks.
    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int HEAP_AW    = $clog2(HEAP_WORDS);
    localparam int CLS_W      = $clog2(SIZE_CLASSES + 1);
    localparam int SLOT_W     = $clog2(SLOTS_PER_CLASS);
    localparam int HK_W       = CLS_W + SLOT_W;
    localparam int HK_N       = SIZE_CLASSES * SLOTS_PER_CLASS;
    localparam int JIX_W      = (HEAP_AW > HK_W) ? HEAP_AW : HK_W;
    localparam int JR_D       = 32;
    localparam int JR_AW      = $clog2(JR_D);

    localparam logic [31:0] MIN_BLOCK = 32'd16;
    localparam logic [31:0] FL_BITS   = 32'd3;
    localparam logic [31:0] AT_SIZE   = 32'd4;
    localparam logic [31:0] AT_FWD    = 32'd8;
    localparam logic [31:0] AT_BWD    = 32'd12;
    localparam logic [31:0] GRAIN32   = 32'(GRAIN_BYTES);
    localparam logic [31:0] PAY_OFS   = 32'd4 + GRAIN32;
    localparam logic [SLOTS_PER_CLASS-1:0] SLOT_ALL = '1;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_RESIZE = 2'd2;
    localparam logic [1:0] MODE_REGION = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OOM      = 2'd1;
    localparam logic [1:0] ST_NORESIZE = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] size_bytes;
        logic [15:0] address;
    } t_req;

    typedef struct packed {
        logic [15:0] block_address;
        logic [1:0]  status;
    } t_rsp;

    // One undo record: target store, word index and the value it held.
    typedef struct packed {
        logic             hd;
        logic [JIX_W-1:0] ix;
        logic [31:0]      old;
    } t_jent;

    typedef struct packed {
        logic             ok;
        logic [CLS_W-1:0] c;
        logic [SLOT_W-1:0] s;
    } t_cls;

    typedef struct packed {
        logic [5:0]  c;
        logic [SLOT_W-1:0] s;
    } t_acls;

    function automatic logic [4:0] f_top_bit(input logic [31:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [HEAP_AW-1:0] f_widx(input logic [31:0] a);
        return a[HEAP_AW+1:2];
    endfunction

    function automatic logic [31:0] f_round_need(input logic [15:0] b);
        logic [31:0] n;
        n = {16'b0, b} + GRAIN32;
        if (n < MIN_BLOCK) begin
            n = MIN_BLOCK;
        end
        return (n + GRAIN32 - 32'd1) & ~(GRAIN32 - 32'd1);
    endfunction

    function automatic t_cls f_classify(input logic [31:0] sz);
        t_cls r;
        logic [4:0] l;
        logic [31:0] sh;
        l = f_top_bit(sz);
        sh = sz >> (l - 5'd2);
        r.ok = (sz >= MIN_BLOCK) && ({27'b0, l} < 32'(SIZE_CLASSES));
        r.c = CLS_W'(l);
        r.s = sh[SLOT_W-1:0];
        return r;
    endfunction

    // Rounds a request up to the next slot boundary.
    function automatic t_acls f_alloc_cls(input logic [31:0] need);
        t_acls r;
        logic [4:0] l;
        logic [31:0] sh;
        logic [2:0] s3;
        l = f_top_bit(need);
        sh = need >> (l - 5'd2);
        r.c = {1'b0, l};
        s3 = {1'b0, sh[1:0]};
        if ((need & ~(32'd1 << l)) != 32'd0) begin
            s3 = s3 + 3'd1;
            if (s3 == 3'(SLOTS_PER_CLASS)) begin
                s3 = '0;
                r.c = r.c + 6'd1;
            end
        end
        r.s = s3[SLOT_W-1:0];
        return r;
    endfunction

endpackage

// ----- src/tlsf_ram.sv -----
// Simple dual-port synchronous RAM with one write port and a registered read port.
module tlsf_ram
    import tlsf_pkg::*;
#(
    parameter int W  = 32,
    parameter int D  = 16,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- src/two_level_segregated_fit_allocator.sv -----
// Top level: request sequencer of the two-level segregated-fit heap manager.
//
//  port      dir  width  role
//  start     in   1      request strobe, taken when busy is low
//  i_req     in   34     mode, size_bytes, address
//  busy      out  1      a request is in progress
//  o_done    out  1      one-cycle result strobe
//  o_rsp     out  18     block_address, status
//
// Every header and link write is a read of the old word and then a journaled
// write on the heap RAM, and a failed request walks its undo journal back
// entry by entry, newest first.
// Reset clears the bitmaps and the control state; heap and list heads are
// left as they are. The result is shown for one cycle and cannot be stalled.
module two_level_segregated_fit_allocator
    import tlsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    typedef enum logic [6:0] {
        S_IDLE, S_WA, S_WB, S_HA, S_HB,
        S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P11, S_P12,
        S_P13,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F4A, S_F4B, S_F5, S_F6, S_F7, S_F8, S_F9,
        S_F10, S_F10B, S_F10C, S_F10D, S_F11, S_F12, S_F14,
        S_R0, S_R1, S_R2, S_R3, S_R4, S_R4B, S_R5, S_R6, S_R7, S_R8, S_R9,
        S_R10, S_R10B, S_R11, S_R12,
        S_G0, S_G1, S_OK, S_RB0, S_RB1
    } t_state;

    t_state r_state, n_state, r_wret, n_wret, r_tret, n_tret, r_pret, n_pret;

    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_bytes, n_bytes, r_where, n_where, r_addr, n_addr;
    logic [31:0] r_wa, n_wa, r_wv, n_wv, r_hv, n_hv;
    logic [HK_W-1:0] r_hk, n_hk, r_k, n_k;
    logic [31:0] r_h, n_h, r_pb, n_pb, r_nb, n_nb, r_t, n_t, r_lf, n_lf;
    logic [31:0] r_w, n_w, r_need, n_need, r_cur, n_cur, r_rem, n_rem, r_nsz, n_nsz;
    logic [31:0] r_th, n_th, r_tsz, n_tsz, r_fw, n_fw, r_bw, n_bw;
    logic [31:0] r_ph, n_ph, r_psz, n_psz, r_first, n_first, r_last, n_last;
    logic [CLS_W-1:0] r_c, n_c;
    logic [SLOT_W-1:0] r_s, n_s;
    logic [1:0]  r_st, n_st;
    logic [JR_AW:0] r_jn, n_jn;
    logic [SIZE_CLASSES-1:0] r_class, n_class, r_keep_class, n_keep_class;
    logic [SIZE_CLASSES-1:0][SLOTS_PER_CLASS-1:0] r_slot, n_slot, r_keep_slot, n_keep_slot;
    logic r_done, n_done;
    t_rsp r_rsp, n_rsp;

    logic               heap_we;
    logic [HEAP_AW-1:0] heap_waddr, heap_raddr;
    logic [31:0]        heap_wdata, heap_q;
    logic               hd_we;
    logic [HK_W-1:0]    hd_waddr, hd_raddr;
    logic [31:0]        hd_wdata, heads_q;
    logic               jr_we;
    logic [JR_AW-1:0]   jr_waddr, jr_raddr;
    t_jent              jr_wdata, jr_q;

    tlsf_ram #(.W(32), .D(HEAP_WORDS), .AW(HEAP_AW)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_waddr), .i_wdata(heap_wdata),
        .i_raddr(heap_raddr), .o_rdata(heap_q)
    );

    tlsf_ram #(.W(32), .D(HK_N), .AW(HK_W)) u_heads (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(heads_q)
    );

    tlsf_ram #(.W($bits(t_jent)), .D(JR_D), .AW(JR_AW)) u_jrnl (
        .i_clk(i_clk), .i_we(jr_we), .i_waddr(jr_waddr), .i_wdata(jr_wdata),
        .i_raddr(jr_raddr), .o_rdata(jr_q)
    );

    always_comb begin
        t_acls v_ac;
        t_cls v_cls;
        logic [31:0] v_need, v_cur, v_rem;
        logic [CLS_W-1:0] v_c2, v_f;
        logic v_fok, v_sok;
        logic [SLOT_W-1:0] v_s;
        logic [SLOTS_PER_CLASS-1:0] v_smask, v_sl;
        logic [SIZE_CLASSES-1:0] v_avail;

        n_state = r_state; n_wret = r_wret; n_tret = r_tret; n_pret = r_pret;
        n_mode = r_mode; n_bytes = r_bytes; n_where = r_where; n_addr = r_addr;
        n_wa = r_wa; n_wv = r_wv; n_hv = r_hv; n_hk = r_hk; n_k = r_k;
        n_h = r_h; n_pb = r_pb; n_nb = r_nb; n_t = r_t; n_lf = r_lf;
        n_w = r_w; n_need = r_need; n_cur = r_cur; n_rem = r_rem; n_nsz = r_nsz;
        n_th = r_th; n_tsz = r_tsz; n_fw = r_fw; n_bw = r_bw;
        n_ph = r_ph; n_psz = r_psz; n_first = r_first; n_last = r_last;
        n_c = r_c; n_s = r_s; n_st = r_st; n_jn = r_jn;
        n_class = r_class; n_slot = r_slot;
        n_keep_class = r_keep_class; n_keep_slot = r_keep_slot;
        n_done = 1'b0; n_rsp = r_rsp;
        heap_we = 1'b0; heap_waddr = '0; heap_wdata = '0; heap_raddr = '0;
        hd_we = 1'b0; hd_waddr = '0; hd_wdata = '0; hd_raddr = '0;
        jr_we = 1'b0; jr_waddr = '0; jr_wdata = '0; jr_raddr = '0;
        v_ac = '0; v_cls = '0; v_need = '0; v_cur = '0; v_rem = '0;
        v_c2 = '0; v_f = '0; v_fok = 1'b0; v_sok = 1'b0; v_s = '0;
        v_smask = '0; v_sl = '0; v_avail = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode = i_req.mode;
                    n_bytes = i_req.size_bytes;
                    n_where = i_req.address;
                    n_addr = '0;
                    n_jn = '0;
                    n_keep_class = r_class;
                    n_keep_slot = r_slot;
                    case (i_req.mode)
                        MODE_ALLOC:  n_state = S_A0;
                        MODE_FREE:   n_state = S_F0;
                        MODE_RESIZE: begin
                            if (i_req.address == 16'd0) begin
                                n_state = S_A0;
                            end else if (i_req.size_bytes == 16'd0) begin
                                n_state = S_F0;
                            end else begin
                                n_state = S_R0;
                            end
                        end
                        default:     n_state = S_G0;
                    endcase
                end
            end
            // Journaled heap write: fetch the old word, then write and log it.
            S_WA: begin
                heap_raddr = f_widx(r_wa);
                n_state = S_WB;
            end
            S_WB: begin
                heap_we = 1'b1;
                heap_waddr = f_widx(r_wa);
                heap_wdata = r_wv;
                jr_we = 1'b1;
                jr_waddr = r_jn[JR_AW-1:0];
                jr_wdata = '{hd: 1'b0, ix: JIX_W'(f_widx(r_wa)), old: heap_q};
                n_jn = r_jn + 1'b1;
                n_state = r_wret;
            end
            S_HA: begin
                hd_raddr = r_hk;
                n_state = S_HB;
            end
            S_HB: begin
                hd_we = 1'b1;
                hd_waddr = r_hk;
                hd_wdata = r_hv;
                jr_we = 1'b1;
                jr_waddr = r_jn[JR_AW-1:0];
                jr_wdata = '{hd: 1'b1, ix: JIX_W'(r_hk), old: heads_q};
                n_jn = r_jn + 1'b1;
                n_state = r_wret;
            end

            // Allocate.
            S_A0: begin
                v_need = f_round_need(r_bytes);
                n_need = v_need;
                v_ac = f_alloc_cls(v_need);
                if ({26'b0, v_ac.c} >= 32'(SIZE_CLASSES)) begin
                    n_st = ST_OOM; n_state = S_RB0;
                end else begin
                    n_c = CLS_W'(v_ac.c);
                    n_s = v_ac.s;
                    n_state = S_A1;
                end
            end
            S_A1: begin
                v_smask = SLOT_ALL << r_s;
                v_c2 = r_c;
                if ((r_slot[r_c] & v_smask) == '0) begin
                    v_c2 = r_c + 1'b1;
                    v_smask = SLOT_ALL;
                end
                for (int i = 0; i < SIZE_CLASSES; i++) begin
                    v_avail[i] = r_class[i] && (32'(i) >= 32'(v_c2));
                end
                for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
                    if (v_avail[i]) begin
                        v_f = CLS_W'(i);
                        v_fok = 1'b1;
                    end
                end
                v_sl = r_slot[v_f] & v_smask;
                for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
                    if (v_sl[i]) begin
                        v_s = SLOT_W'(i);
                        v_sok = 1'b1;
                    end
                end
                if (!v_fok) begin
                    n_st = ST_OOM; n_state = S_RB0;
                end else if (!v_sok) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_k = {v_f, v_s};
                    hd_raddr = {v_f, v_s};
                    n_state = S_A2;
                end
            end
            S_A2: begin
                n_h = heads_q;
                heap_raddr = f_widx(heads_q + AT_SIZE);
                n_state = S_A3;
            end
            S_A3: begin
                if ((heap_q & ~FL_BITS) < r_need) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_th = r_h; n_tret = S_A4; n_state = S_T0;
                end
            end
            S_A4: begin
                heap_raddr = f_widx(r_h + AT_SIZE);
                n_state = S_A5;
            end
            S_A5: begin
                v_rem = (heap_q & ~FL_BITS) - r_need;
                n_rem = v_rem;
                v_need = r_h + PAY_OFS;
                n_addr = v_need[15:0];
                if (v_rem >= MIN_BLOCK) begin
                    n_wa = r_h + AT_SIZE; n_wv = (heap_q & FL_BITS) | r_need;
                    n_wret = S_A6; n_state = S_WA;
                end else begin
                    n_state = S_OK;
                end
            end
            S_A6: begin
                n_ph = r_h + r_need; n_psz = r_rem; n_pret = S_OK; n_state = S_P0;
            end

            // Unlink a free block r_th from its list.
            S_T0: begin
                heap_raddr = f_widx(r_th + AT_SIZE);
                n_state = S_T1;
            end
            S_T1: begin
                v_cls = f_classify(heap_q & ~FL_BITS);
                if (!heap_q[0] || !v_cls.ok) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_tsz = heap_q & ~FL_BITS;
                    n_c = v_cls.c; n_s = v_cls.s; n_k = {v_cls.c, v_cls.s};
                    n_wa = r_th + AT_SIZE; n_wv = heap_q & ~32'd1;
                    n_wret = S_T2; n_state = S_WA;
                end
            end
            S_T2: begin
                heap_raddr = f_widx(r_th + AT_FWD);
                n_state = S_T3;
            end
            S_T3: begin
                n_fw = heap_q;
                heap_raddr = f_widx(r_th + AT_BWD);
                n_state = S_T4;
            end
            S_T4: begin
                n_bw = heap_q;
                if (r_fw == r_th) begin
                    n_slot[r_c][r_s] = 1'b0;
                    n_state = S_T8;
                end else begin
                    n_wa = heap_q + AT_FWD; n_wv = r_fw; n_wret = S_T5; n_state = S_WA;
                end
            end
            S_T5: begin
                n_wa = r_fw + AT_BWD; n_wv = r_bw; n_wret = S_T6; n_state = S_WA;
            end
            S_T6: begin
                hd_raddr = r_k;
                n_state = S_T7;
            end
            S_T7: begin
                if (heads_q == r_th) begin
                    n_hk = r_k; n_hv = r_fw; n_wret = S_T8; n_state = S_HA;
                end else begin
                    n_state = S_T8;
                end
            end
            S_T8: begin
                if (r_slot[r_c] == '0) begin
                    n_class[r_c] = 1'b0;
                end
                heap_raddr = f_widx(r_th + r_tsz + AT_SIZE);
                n_state = S_T9;
            end
            S_T9: begin
                if (!heap_q[1]) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_wa = r_th + r_tsz + AT_SIZE; n_wv = heap_q & ~32'd2;
                    n_wret = r_tret; n_state = S_WA;
                end
            end

            // Mark r_ph free with size r_psz and push it on its list.
            S_P0: begin
                n_wa = r_ph + AT_SIZE; n_wv = r_psz | 32'd1; n_wret = S_P1; n_state = S_WA;
            end
            S_P1: begin
                n_wa = r_ph + r_psz; n_wv = r_ph; n_wret = S_P2; n_state = S_WA;
            end
            S_P2: begin
                heap_raddr = f_widx(r_ph + r_psz + AT_SIZE);
                n_state = S_P3;
            end
            S_P3: begin
                n_wa = r_ph + r_psz + AT_SIZE; n_wv = heap_q | 32'd2;
                n_wret = S_P4; n_state = S_WA;
            end
            S_P4: begin
                v_cls = f_classify(r_psz);
                if (!v_cls.ok) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_c = v_cls.c; n_s = v_cls.s; n_k = {v_cls.c, v_cls.s};
                    if (r_slot[v_cls.c][v_cls.s]) begin
                        hd_raddr = {v_cls.c, v_cls.s};
                        n_state = S_P5;
                    end else begin
                        n_wa = r_ph + AT_FWD; n_wv = r_ph; n_wret = S_P11; n_state = S_WA;
                    end
                end
            end
            S_P5: begin
                n_first = heads_q;
                heap_raddr = f_widx(heads_q + AT_BWD);
                n_state = S_P6;
            end
            S_P6: begin
                n_last = heap_q;
                n_wa = r_ph + AT_FWD; n_wv = r_first; n_wret = S_P7; n_state = S_WA;
            end
            S_P7: begin
                n_wa = r_ph + AT_BWD; n_wv = r_last; n_wret = S_P8; n_state = S_WA;
            end
            S_P8: begin
                n_wa = r_last + AT_FWD; n_wv = r_ph; n_wret = S_P9; n_state = S_WA;
            end
            S_P9: begin
                n_wa = r_first + AT_BWD; n_wv = r_ph; n_wret = S_P12; n_state = S_WA;
            end
            S_P11: begin
                n_wa = r_ph + AT_BWD; n_wv = r_ph; n_wret = S_P12; n_state = S_WA;
            end
            S_P12: begin
                n_hk = r_k; n_hv = r_ph; n_wret = S_P13; n_state = S_HA;
            end
            S_P13: begin
                n_slot[r_c][r_s] = 1'b1;
                n_class[r_c] = 1'b1;
                n_state = r_pret;
            end

            // Free.
            S_F0: begin
                if (r_where == 16'd0) begin
                    n_state = S_OK;
                end else if ((r_where % GRAIN_BYTES) != 16'd0) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_h = {16'b0, r_where} - PAY_OFS;
                    heap_raddr = f_widx({16'b0, r_where} - PAY_OFS + AT_SIZE);
                    n_state = S_F1;
                end
            end
            S_F1: begin
                n_w = heap_q;
                if (heap_q[0] || (heap_q & ~FL_BITS) < MIN_BLOCK) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else if (heap_q[1]) begin
                    heap_raddr = f_widx(r_h);
                    n_state = S_F2;
                end else begin
                    n_state = S_F5;
                end
            end
            S_F2: begin
                n_pb = heap_q;
                heap_raddr = f_widx(heap_q + AT_SIZE);
                n_state = S_F3;
            end
            S_F3: begin
                if (!heap_q[0] || heap_q[1]) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_th = r_pb; n_tret = S_F4; n_state = S_T0;
                end
            end
            S_F4: begin
                heap_raddr = f_widx(r_pb + AT_SIZE);
                n_state = S_F4A;
            end
            S_F4A: begin
                n_wa = r_pb + AT_SIZE; n_wv = heap_q + (r_w & ~FL_BITS);
                n_wret = S_F4B; n_state = S_WA;
            end
            S_F4B: begin
                n_h = r_pb;
                n_state = S_F5;
            end
            S_F5: begin
                heap_raddr = f_widx(r_h + AT_SIZE);
                n_state = S_F6;
            end
            S_F6: begin
                n_nb = r_h + (heap_q & ~FL_BITS);
                heap_raddr = f_widx(r_h + (heap_q & ~FL_BITS) + AT_SIZE);
                n_state = S_F7;
            end
            S_F7: begin
                if (heap_q[0]) begin
                    if (heap_q[1]) begin
                        n_st = ST_BAD; n_state = S_RB0;
                    end else begin
                        n_th = r_nb; n_tret = S_F8; n_state = S_T0;
                    end
                end else begin
                    n_state = S_F11;
                end
            end
            S_F8: begin
                heap_raddr = f_widx(r_nb + AT_SIZE);
                n_state = S_F9;
            end
            S_F9: begin
                n_nsz = heap_q & ~FL_BITS;
                heap_raddr = f_widx(r_h + AT_SIZE);
                n_state = S_F10;
            end
            S_F10: begin
                n_wa = r_h + AT_SIZE; n_wv = heap_q + r_nsz; n_wret = S_F10B; n_state = S_WA;
            end
            S_F10B: begin
                heap_raddr = f_widx(r_h + AT_SIZE);
                n_state = S_F10C;
            end
            S_F10C: begin
                n_nb = r_h + (heap_q & ~FL_BITS);
                heap_raddr = f_widx(r_h + (heap_q & ~FL_BITS) + AT_SIZE);
                n_state = S_F10D;
            end
            S_F10D: begin
                if (heap_q[0]) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_state = S_F11;
                end
            end
            S_F11: begin
                heap_raddr = f_widx(r_nb + AT_SIZE);
                n_state = S_F12;
            end
            S_F12: begin
                if (heap_q[1]) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    heap_raddr = f_widx(r_h + AT_SIZE);
                    n_state = S_F14;
                end
            end
            S_F14: begin
                n_ph = r_h; n_psz = heap_q & ~FL_BITS; n_pret = S_OK; n_state = S_P0;
            end

            // Resize in place.
            S_R0: begin
                n_addr = r_where;
                if ((r_where % GRAIN_BYTES) != 16'd0) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_h = {16'b0, r_where} - PAY_OFS;
                    heap_raddr = f_widx({16'b0, r_where} - PAY_OFS + AT_SIZE);
                    n_state = S_R1;
                end
            end
            S_R1: begin
                v_cur = heap_q & ~FL_BITS;
                v_need = f_round_need(r_bytes);
                n_cur = v_cur; n_w = heap_q; n_need = v_need;
                if (heap_q[0] || v_cur < MIN_BLOCK) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else if (v_need > v_cur) begin
                    n_nb = r_h + v_cur;
                    heap_raddr = f_widx(r_h + v_cur + AT_SIZE);
                    n_state = S_R2;
                end else begin
                    n_state = S_R5;
                end
            end
            S_R2: begin
                if (heap_q[1]) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else if (!heap_q[0] ||
                             ({1'b0, r_cur} + {1'b0, heap_q & ~FL_BITS}) < {1'b0, r_need}) begin
                    n_st = ST_NORESIZE; n_state = S_RB0;
                end else begin
                    n_th = r_nb; n_tret = S_R3; n_state = S_T0;
                end
            end
            S_R3: begin
                heap_raddr = f_widx(r_nb + AT_SIZE);
                n_state = S_R4;
            end
            S_R4: begin
                n_nsz = heap_q & ~FL_BITS;
                heap_raddr = f_widx(r_h + AT_SIZE);
                n_state = S_R4B;
            end
            S_R4B: begin
                n_wa = r_h + AT_SIZE; n_wv = heap_q + r_nsz; n_wret = S_R5; n_state = S_WA;
            end
            S_R5: begin
                heap_raddr = f_widx(r_h + AT_SIZE);
                n_state = S_R6;
            end
            S_R6: begin
                v_cur = heap_q & ~FL_BITS;
                if ({1'b0, v_cur} >= ({1'b0, r_need} + {1'b0, MIN_BLOCK})) begin
                    n_rem = v_cur - r_need;
                    n_lf = r_h + r_need;
                    n_wa = r_h + AT_SIZE; n_wv = (heap_q & FL_BITS) | r_need;
                    n_wret = S_R7; n_state = S_WA;
                end else begin
                    n_state = S_OK;
                end
            end
            S_R7: begin
                n_wa = r_lf + AT_SIZE; n_wv = r_rem; n_wret = S_R8; n_state = S_WA;
            end
            S_R8: begin
                n_t = r_lf + r_rem;
                heap_raddr = f_widx(r_lf + r_rem + AT_SIZE);
                n_state = S_R9;
            end
            S_R9: begin
                if (heap_q[0]) begin
                    n_th = r_t; n_tret = S_R10; n_state = S_T0;
                end else begin
                    n_state = S_R11;
                end
            end
            S_R10: begin
                heap_raddr = f_widx(r_t + AT_SIZE);
                n_state = S_R10B;
            end
            S_R10B: begin
                n_wa = r_lf + AT_SIZE; n_wv = r_rem + (heap_q & ~FL_BITS);
                n_wret = S_R11; n_state = S_WA;
            end
            S_R11: begin
                heap_raddr = f_widx(r_lf + AT_SIZE);
                n_state = S_R12;
            end
            S_R12: begin
                n_ph = r_lf; n_psz = heap_q & ~FL_BITS; n_pret = S_OK; n_state = S_P0;
            end

            // Add region: a zero end marker, then one free block over the rest.
            S_G0: begin
                if ({16'b0, r_bytes} <= MIN_BLOCK || r_bytes[3:0] != 4'd0 ||
                    (r_where % GRAIN_BYTES) != 16'd0 ||
                    ({16'b0, r_where} + {16'b0, r_bytes}) > 32'(HEAP_BYTES)) begin
                    n_st = ST_BAD; n_state = S_RB0;
                end else begin
                    n_wa = {16'b0, r_where} + {16'b0, r_bytes} - PAY_OFS + AT_SIZE;
                    n_wv = '0; n_wret = S_G1; n_state = S_WA;
                end
            end
            S_G1: begin
                n_ph = {16'b0, r_where} - 32'd4;
                n_psz = {16'b0, r_bytes} - GRAIN32;
                n_pret = S_OK;
                n_state = S_P0;
            end

            S_OK: begin
                n_rsp = '{block_address: r_addr, status: ST_OK};
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            // Undo the journal newest first, then restore the bitmaps.
            S_RB0: begin
                if (r_jn == '0) begin
                    n_class = r_keep_class;
                    n_slot = r_keep_slot;
                    n_rsp = '{block_address: 16'd0, status: r_st};
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    jr_raddr = JR_AW'(r_jn - 1'b1);
                    n_state = S_RB1;
                end
            end
            S_RB1: begin
                if (jr_q.hd) begin
                    hd_we = 1'b1;
                    hd_waddr = jr_q.ix[HK_W-1:0];
                    hd_wdata = jr_q.old;
                end else begin
                    heap_we = 1'b1;
                    heap_waddr = jr_q.ix[HEAP_AW-1:0];
                    heap_wdata = jr_q.old;
                end
                n_jn = r_jn - 1'b1;
                n_state = S_RB0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_jn <= '0;
            r_done <= 1'b0;
            r_class <= '0;
            r_slot <= '0;
        end else begin
            r_state <= n_state;
            r_jn <= n_jn;
            r_done <= n_done;
            r_class <= n_class;
            r_slot <= n_slot;
        end
        r_wret <= n_wret; r_tret <= n_tret; r_pret <= n_pret;
        r_mode <= n_mode; r_bytes <= n_bytes; r_where <= n_where; r_addr <= n_addr;
        r_wa <= n_wa; r_wv <= n_wv; r_hv <= n_hv; r_hk <= n_hk; r_k <= n_k;
        r_h <= n_h; r_pb <= n_pb; r_nb <= n_nb; r_t <= n_t; r_lf <= n_lf;
        r_w <= n_w; r_need <= n_need; r_cur <= n_cur; r_rem <= n_rem; r_nsz <= n_nsz;
        r_th <= n_th; r_tsz <= n_tsz; r_fw <= n_fw; r_bw <= n_bw;
        r_ph <= n_ph; r_psz <= n_psz; r_first <= n_first; r_last <= n_last;
        r_c <= n_c; r_s <= n_s; r_st <= n_st;
        r_keep_class <= n_keep_class; r_keep_slot <= n_keep_slot;
        r_rsp <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_fail_undone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |-> (r_jn == '0))
        else $error("failed request left journal entries undone");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |-> (o_rsp.block_address == 16'd0))
        else $error("failed request returned an address");
`endif

endmodule

// ----- tb/sv/tb_two_level_segregated_fit_allocator.sv -----
// Self-checking testbench of the two-level segregated-fit heap manager.
module tb_two_level_segregated_fit_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import tlsf_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int UNDO_CAP     = 128;
    localparam logic [31:0] FREE_BIT  = 32'd1;
    localparam logic [31:0] PFREE_BIT = 32'd2;
    localparam logic [31:0] SLOTS_M   = 32'(SLOT_ALL);

    // Shadow heap manager plus the store of expected results.
    class heap_scoreboard;
        logic [31:0] heap [HEAP_WORDS];
        bit          seen [HEAP_WORDS];
        logic [31:0] cls_map;
        logic [31:0] slot_map [SIZE_CLASSES];
        logic [31:0] heads [HK_N];
        logic [31:0] kept_cls;
        logic [31:0] kept_slot [SIZE_CLASSES];
        logic [31:0] kept_heads [HK_N];
        int unsigned undo_idx [$];
        logic [31:0] undo_old [$];
        bit          undo_seen [$];
        bit          broken;
        bit          touched;
        t_rsp        pending [$];
        int          errors;
        int          checked;
        int          by_status [4];
        int          by_mode [4];

        function void clear();
            for (int i = 0; i < HEAP_WORDS; i++) begin
                heap[i] = '0;
                seen[i] = 0;
            end
            for (int i = 0; i < SIZE_CLASSES; i++) slot_map[i] = '0;
            for (int i = 0; i < HK_N; i++) heads[i] = '0;
            cls_map = '0;
            errors = 0;
            checked = 0;
        endfunction

        function logic [31:0] rd(logic [31:0] a);
            int unsigned i;
            i = (a >> 2) % HEAP_WORDS;
            if (!seen[i]) touched = 1;
            return heap[i];
        endfunction

        function void wr(logic [31:0] a, logic [31:0] v);
            int unsigned i;
            i = (a >> 2) % HEAP_WORDS;
            if (undo_idx.size() >= UNDO_CAP) begin
                broken = 1;
                return;
            end
            undo_idx.push_back(i);
            undo_old.push_back(heap[i]);
            undo_seen.push_back(seen[i]);
            heap[i] = v;
            seen[i] = 1;
        endfunction

        function void revert();
            while (undo_idx.size() > 0) begin
                heap[undo_idx[$]] = undo_old.pop_back();
                seen[undo_idx[$]] = undo_seen.pop_back();
                void'(undo_idx.pop_back());
            end
            cls_map = kept_cls;
            slot_map = kept_slot;
            heads = kept_heads;
        endfunction

        function int hi_bit(logic [31:0] x);
            for (int i = 31; i >= 0; i--) if (x[i]) return i;
            return -1;
        endfunction

        function int lo_bit(logic [31:0] x);
            for (int i = 0; i < 32; i++) if (x[i]) return i;
            return -1;
        endfunction

        function logic [31:0] block_size(logic [31:0] h);
            return rd(h + AT_SIZE) & ~FL_BITS;
        endfunction

        function logic [31:0] needed(logic [31:0] b);
            logic [31:0] n;
            n = b + GRAIN32;
            if (n < MIN_BLOCK) n = MIN_BLOCK;
            return (n + GRAIN32 - 1) / GRAIN32 * GRAIN32;
        endfunction

        function bit size_class(logic [31:0] sz, output int c, output int s);
            int l;
            c = 0;
            s = 0;
            if (sz < MIN_BLOCK) begin
                broken = 1;
                return 0;
            end
            l = hi_bit(sz);
            if (l >= SIZE_CLASSES) begin
                broken = 1;
                return 0;
            end
            c = l;
            s = int'(((sz - (32'd1 << l)) >> (l - 2)) & SLOTS_M);
            return 1;
        endfunction

        function void link_free(logic [31:0] h, logic [31:0] sz);
            int c, s, k;
            logic [31:0] t, first, last;
            t = h + sz;
            wr(h + AT_SIZE, sz | FREE_BIT);
            wr(t, h);
            wr(t + AT_SIZE, rd(t + AT_SIZE) | PFREE_BIT);
            if (!size_class(sz, c, s)) return;
            k = c * SLOTS_PER_CLASS + s;
            if (slot_map[c][s]) begin
                first = heads[k];
                last = rd(first + AT_BWD);
                wr(h + AT_FWD, first);
                wr(h + AT_BWD, last);
                wr(last + AT_FWD, h);
                wr(first + AT_BWD, h);
            end else begin
                wr(h + AT_FWD, h);
                wr(h + AT_BWD, h);
            end
            heads[k] = h;
            slot_map[c][s] = 1'b1;
            cls_map[c] = 1'b1;
        endfunction

        function void unlink_free(logic [31:0] h);
            int c, s, k;
            logic [31:0] word, sz, fw, bw, t, ts;
            word = rd(h + AT_SIZE);
            sz = word & ~FL_BITS;
            if ((word & FREE_BIT) == 0) begin
                broken = 1;
                return;
            end
            if (!size_class(sz, c, s)) return;
            k = c * SLOTS_PER_CLASS + s;
            wr(h + AT_SIZE, word & ~FREE_BIT);
            fw = rd(h + AT_FWD);
            bw = rd(h + AT_BWD);
            if (fw == h) begin
                slot_map[c][s] = 1'b0;
            end else begin
                wr(bw + AT_FWD, fw);
                wr(fw + AT_BWD, bw);
                if (heads[k] == h) heads[k] = fw;
            end
            if (slot_map[c] == 0) cls_map[c] = 1'b0;
            t = h + sz;
            ts = rd(t + AT_SIZE);
            if ((ts & PFREE_BIT) == 0) begin
                broken = 1;
                return;
            end
            wr(t + AT_SIZE, ts & ~PFREE_BIT);
        endfunction

        function logic [1:0] allocate(logic [31:0] bytes, output logic [31:0] addr);
            logic [31:0] need, over, smask, cmask, avail, h, rem;
            int l, c, s, f;
            addr = '0;
            need = needed(bytes);
            l = hi_bit(need);
            over = need - (32'd1 << l);
            c = l;
            s = int'(over >> (l - 2));
            if (over != 0) begin
                s++;
                if (s == SLOTS_PER_CLASS) begin
                    s = 0;
                    c++;
                end
            end
            if (c >= SIZE_CLASSES) return ST_OOM;
            smask = (SLOTS_M << s) & SLOTS_M;
            if ((slot_map[c] & smask) == 0) begin
                c++;
                smask = SLOTS_M;
            end
            cmask = (c >= 32) ? 32'd0 : ~((32'd1 << c) - 1);
            avail = cls_map & cmask;
            f = lo_bit(avail);
            if (f < 0 || f >= SIZE_CLASSES) return ST_OOM;
            c = f;
            f = lo_bit(slot_map[c] & smask);
            if (f < 0) return ST_BAD;
            h = heads[c * SLOTS_PER_CLASS + f];
            if (block_size(h) < need) return ST_BAD;
            unlink_free(h);
            if (broken) return ST_BAD;
            rem = block_size(h) - need;
            if (rem >= MIN_BLOCK) begin
                wr(h + AT_SIZE, (rd(h + AT_SIZE) & FL_BITS) | need);
                link_free(h + need, rem);
            end
            addr = h + PAY_OFS;
            return ST_OK;
        endfunction

        function logic [1:0] release_block(logic [31:0] blk);
            logic [31:0] h, w, nb, pb, pw;
            if (blk == 0) return ST_OK;
            if (blk % GRAIN32 != 0) return ST_BAD;
            h = blk - PAY_OFS;
            w = rd(h + AT_SIZE);
            if ((w & FREE_BIT) != 0 || (w & ~FL_BITS) < MIN_BLOCK) return ST_BAD;
            if ((w & PFREE_BIT) != 0) begin
                pb = rd(h);
                pw = rd(pb + AT_SIZE);
                if ((pw & FREE_BIT) == 0 || (pw & PFREE_BIT) != 0) return ST_BAD;
                unlink_free(pb);
                if (broken) return ST_BAD;
                wr(pb + AT_SIZE, rd(pb + AT_SIZE) + (w & ~FL_BITS));
                h = pb;
            end
            nb = h + block_size(h);
            if ((rd(nb + AT_SIZE) & FREE_BIT) != 0) begin
                if ((rd(nb + AT_SIZE) & PFREE_BIT) != 0) return ST_BAD;
                unlink_free(nb);
                if (broken) return ST_BAD;
                wr(h + AT_SIZE, rd(h + AT_SIZE) + block_size(nb));
                nb = h + block_size(h);
                if ((rd(nb + AT_SIZE) & FREE_BIT) != 0) return ST_BAD;
            end
            if ((rd(nb + AT_SIZE) & PFREE_BIT) != 0) return ST_BAD;
            link_free(h, block_size(h));
            return ST_OK;
        endfunction

        function logic [1:0] resize(logic [31:0] blk, logic [31:0] bytes,
                                    output logic [31:0] addr);
            logic [31:0] h, w, need, cur, nb, nw, rem, lf, t;
            addr = '0;
            if (blk == 0) return allocate(bytes, addr);
            if (bytes == 0) return release_block(blk);
            if (blk % GRAIN32 != 0) return ST_BAD;
            h = blk - PAY_OFS;
            w = rd(h + AT_SIZE);
            cur = w & ~FL_BITS;
            if ((w & FREE_BIT) != 0 || cur < MIN_BLOCK) return ST_BAD;
            need = needed(bytes);
            if (need > cur) begin
                nb = h + cur;
                nw = rd(nb + AT_SIZE);
                if ((nw & PFREE_BIT) != 0) return ST_BAD;
                if ((nw & FREE_BIT) == 0 ||
                    longint'(cur) + longint'(nw & ~FL_BITS) < longint'(need))
                    return ST_NORESIZE;
                unlink_free(nb);
                if (broken) return ST_BAD;
                wr(h + AT_SIZE, rd(h + AT_SIZE) + block_size(nb));
            end
            cur = block_size(h);
            if (cur >= need + MIN_BLOCK) begin
                rem = cur - need;
                lf = h + need;
                wr(h + AT_SIZE, (rd(h + AT_SIZE) & FL_BITS) | need);
                wr(lf + AT_SIZE, rem);
                t = lf + rem;
                if ((rd(t + AT_SIZE) & FREE_BIT) != 0) begin
                    unlink_free(t);
                    if (broken) return ST_BAD;
                    wr(lf + AT_SIZE, rem + block_size(t));
                end
                link_free(lf, block_size(lf));
            end
            addr = blk;
            return ST_OK;
        endfunction

        function logic [1:0] add_region(logic [31:0] base, logic [31:0] len);
            if (len <= MIN_BLOCK || len % MIN_BLOCK != 0) return ST_BAD;
            if (base % GRAIN32 != 0) return ST_BAD;
            if (base + len > 32'(HEAP_BYTES)) return ST_BAD;
            wr(base + len - PAY_OFS + AT_SIZE, 32'd0);
            link_free(base - 4, len - GRAIN32);
            return ST_OK;
        endfunction

        function t_rsp apply(t_req r);
            t_rsp o;
            logic [31:0] addr;
            logic [1:0] st;
            broken = 0;
            touched = 0;
            undo_idx.delete();
            undo_old.delete();
            undo_seen.delete();
            kept_cls = cls_map;
            kept_slot = slot_map;
            kept_heads = heads;
            addr = '0;
            case (r.mode)
                MODE_ALLOC:  st = allocate({16'b0, r.size_bytes}, addr);
                MODE_FREE:   st = release_block({16'b0, r.address});
                MODE_RESIZE: st = resize({16'b0, r.address}, {16'b0, r.size_bytes}, addr);
                default:     st = add_region({16'b0, r.address}, {16'b0, r.size_bytes});
            endcase
            if (broken) st = ST_BAD;
            if (st != ST_OK) begin
                revert();
                addr = '0;
            end
            o.block_address = addr[15:0];
            o.status = st;
            return o;
        endfunction

        // A request that would read heap words never written is never sent.
        function bit reads_only_written(t_req r);
            void'(apply(r));
            revert();
            return !touched;
        endfunction

        function t_rsp note_request(t_req r);
            t_rsp o;
            o = apply(r);
            pending.push_back(o);
            by_mode[r.mode]++;
            by_status[o.status]++;
            return o;
        endfunction

        function void check_result(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.block_address !== e.block_address) begin
                $error("block_address: expected %0h, actual %0h", e.block_address,
                       got.block_address);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    heap_scoreboard sb;
    int cycles;
    int idle_pct;
    logic [15:0] live [$];
    logic [31:0] region_base;

    two_level_segregated_fit_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_rsp);
    end

    task automatic issue(input logic [1:0] mode, input logic [15:0] sz,
                         input logic [15:0] addr, output t_rsp exp, output bit sent);
        t_req r;
        r.mode = mode;
        r.size_bytes = sz;
        r.address = addr;
        exp = '0;
        sent = sb.reads_only_written(r);
        if (!sent) return;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        exp = sb.note_request(r);
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Sends one request and keeps the list of blocks in use up to date.
    task automatic request(input logic [1:0] mode, input logic [15:0] sz,
                           input logic [15:0] addr, output bit sent);
        t_rsp e;
        issue(mode, sz, addr, e, sent);
        if (!sent || e.status != ST_OK) return;
        if (mode == MODE_ALLOC || (mode == MODE_RESIZE && addr == 0)) begin
            live.push_back(e.block_address);
        end else if (mode == MODE_FREE || (mode == MODE_RESIZE && sz == 0)) begin
            foreach (live[i]) begin
                if (live[i] == addr) begin
                    live.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic random_request(output bit sent);
        int pick, n, k;
        logic [15:0] sz, a;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        n = live.size();
        if (pick < 8) begin
            len = 32'd16 * $urandom_range(2, 256);
            if ($urandom_range(0, 3) != 0 && region_base + len <= 32'(HEAP_BYTES)) begin
                request(MODE_REGION, len[15:0], region_base[15:0], sent);
                if (sent) region_base = region_base + len + 32'd16;
            end else begin
                request(MODE_REGION, 16'($urandom), 16'($urandom), sent);
            end
        end else if (pick < 45 && n < 60) begin
            sz = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
            request(MODE_ALLOC, sz, 16'($urandom), sent);
        end else if (pick < 75 && n > 0) begin
            k = $urandom_range(0, n - 1);
            request(MODE_FREE, 16'($urandom), live[k], sent);
        end else if (pick < 93 && n > 0) begin
            k = $urandom_range(0, n - 1);
            case ($urandom_range(0, 5))
                0:       sz = 16'd0;
                1:       sz = 16'($urandom);
                default: sz = 16'($urandom_range(1, 400));
            endcase
            request(MODE_RESIZE, sz, live[k], sent);
        end else begin
            // Malformed or stale addresses and the zero-address forms.
            case ($urandom_range(0, 3))
                0: a = 16'd0;
                1: a = 16'($urandom);
                default: a = 16'($urandom) & 16'hFFFC;
            endcase
            request(logic'($urandom_range(0, 1)) ? MODE_RESIZE : MODE_FREE,
                    16'($urandom_range(0, 200)), a, sent);
        end
    endtask

    initial begin
        t_rsp e, a1, a2;
        bit sent;
        int done_items;
        int waited;
        int pct [4];
        sb = new;
        sb.clear();
        cycles = 0;
        idle_pct = 0;
        region_base = 32'd2048;
        pct = '{0, 53, 0, 27};
        start <= 1'b0;
        i_req <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: region checks, size extremes, zero-address forms, resize cases.
        issue(MODE_REGION, 16'd16, 16'd64, e, sent);
        issue(MODE_REGION, 16'd40, 16'd64, e, sent);
        issue(MODE_REGION, 16'd64, 16'd66, e, sent);
        issue(MODE_REGION, 16'd64, 16'd65520, e, sent);
        issue(MODE_REGION, 16'd1024, 16'd16, e, sent);
        issue(MODE_ALLOC, 16'hFFFF, 16'd0, e, sent);
        issue(MODE_ALLOC, 16'd0, 16'hFFFF, a1, sent);
        issue(MODE_ALLOC, 16'd1, 16'd0, a2, sent);
        issue(MODE_FREE, 16'd0, 16'd0, e, sent);
        issue(MODE_FREE, 16'd0, 16'd3, e, sent);
        issue(MODE_RESIZE, 16'd0, 16'd6, e, sent);
        issue(MODE_RESIZE, 16'd500, a1.block_address, e, sent);
        issue(MODE_RESIZE, 16'd40, 16'd0, e, sent);
        issue(MODE_RESIZE, 16'd600, a2.block_address, e, sent);
        issue(MODE_RESIZE, 16'd20, a2.block_address, e, sent);
        issue(MODE_RESIZE, 16'd0, a2.block_address, e, sent);
        issue(MODE_FREE, 16'd0, a2.block_address, e, sent);
        issue(MODE_FREE, 16'd0, a1.block_address, e, sent);
        issue(MODE_ALLOC, 16'd100, 16'd0, a1, sent);
        issue(MODE_RESIZE, 16'd150, a1.block_address, e, sent);
        issue(MODE_FREE, 16'd0, a1.block_address, e, sent);
        issue(MODE_REGION, 16'd4096, 16'd1200, e, sent);

        done_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = pct[ph];
            while (done_items < (ph + 1) * 500) begin
                random_request(sent);
                if (sent) done_items++;
            end
        end
        start <= 1'b0;

        waited = 0;
        while (sb.pending.size() > 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.pending.size() > 0) begin
            $error("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Checked %0d results: %0d alloc, %0d free, %0d resize, %0d region requests.",
                 sb.checked, sb.by_mode[MODE_ALLOC], sb.by_mode[MODE_FREE],
                 sb.by_mode[MODE_RESIZE], sb.by_mode[MODE_REGION]);
        $display("Statuses seen: %0d ok, %0d out of memory, %0d no resize, %0d invalid.",
                 sb.by_status[ST_OK], sb.by_status[ST_OOM], sb.by_status[ST_NORESIZE],
                 sb.by_status[ST_BAD]);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
